/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker in rrbb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/rrbb_pkg.sv */
package rrbb_pkg;

	localparam int ANGLE_BITS_DEF       = 16;
	localparam int LENGTH_FRAC_BITS_DEF = 4;
	localparam int CORDIC_BITS          = 24;
	localparam int CORDIC_ITERS         = 23;
	localparam int Q_BITS               = 30;
	localparam int XY_W                 = 33;
	localparam int Z_W                  = 25;
	localparam int MAG_W                = 32;
	localparam int PROD_W               = 48;
	localparam int RND_W                = PROD_W - Q_BITS;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	typedef struct packed {
		logic [15:0] half_diagonal;
		logic [15:0] first_corner_angle;
		logic [15:0] second_corner_angle;
		logic [15:0] rotation;
	} item_t;

	typedef struct packed {
		logic [15:0] box_width;
		logic [15:0] box_height;
	} box_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [1:0]             quad;
	} vec_t;

	typedef struct packed {
		vec_t        c1;
		vec_t        c2;
		logic [15:0] len;
	} cell_data_t;

	typedef struct packed {
		logic [RND_W-1:0] x1;
		logic [RND_W-1:0] x2;
		logic [RND_W-1:0] y1;
		logic [RND_W-1:0] y2;
	} offs_t;

	function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
		logic signed [Z_W-1:0] r;
		case (idx)
			0:  r = 25'sd2097152;
			1:  r = 25'sd1238021;
			2:  r = 25'sd654136;
			3:  r = 25'sd332050;
			4:  r = 25'sd166669;
			5:  r = 25'sd83416;
			6:  r = 25'sd41718;
			7:  r = 25'sd20860;
			8:  r = 25'sd10430;
			9:  r = 25'sd5215;
			10: r = 25'sd2608;
			11: r = 25'sd1304;
			12: r = 25'sd652;
			13: r = 25'sd326;
			14: r = 25'sd163;
			15: r = 25'sd81;
			16: r = 25'sd41;
			17: r = 25'sd20;
			18: r = 25'sd10;
			19: r = 25'sd5;
			20: r = 25'sd3;
			21: r = 25'sd1;
			22: r = 25'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/rrbb_cordic_cell.sv */
module rrbb_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  rrbb_pkg::cell_data_t up_data,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output rrbb_pkg::cell_data_t dn_data
);

	function automatic rrbb_pkg::vec_t rot_step(input rrbb_pkg::vec_t v);
		rrbb_pkg::vec_t                           r;
		logic signed [rrbb_pkg::XY_W-1:0]         vx;
		logic signed [rrbb_pkg::XY_W-1:0]         vy;
		logic signed [rrbb_pkg::Z_W-1:0]          vz;
		logic signed [rrbb_pkg::XY_W-1:0]         dx;
		logic signed [rrbb_pkg::XY_W-1:0]         dy;
		logic signed [rrbb_pkg::Z_W-1:0]          at;
		vx = v.x;
		vy = v.y;
		vz = v.z;
		dx = vy >>> STEP;
		dy = vx >>> STEP;
		at = rrbb_pkg::atan_entry(STEP);
		r.quad = v.quad;
		if (!vz[rrbb_pkg::Z_W-1]) begin
			r.x = vx - dx;
			r.y = vy + dy;
			r.z = vz - at;
		end else begin
			r.x = vx + dx;
			r.y = vy - dy;
			r.z = vz + at;
		end
		return r;
	endfunction

	logic                 valid_q;
	rrbb_pkg::cell_data_t data_q;
	logic                 adv;

	assign adv      = !valid_q || dn_ready;
	assign up_ready = adv;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			data_q.c1  <= rot_step(up_data.c1);
			data_q.c2  <= rot_step(up_data.c2);
			data_q.len <= up_data.len;
		end
	end

endmodule

/* rtl/core/rrbb_scale.sv */
module rrbb_scale #(
	parameter int LENGTH_FRAC_BITS = rrbb_pkg::LENGTH_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  rrbb_pkg::cell_data_t up_data,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output rrbb_pkg::offs_t      dn_data
);

	localparam int SH = rrbb_pkg::Q_BITS + LENGTH_FRAC_BITS;
	localparam logic [rrbb_pkg::PROD_W-1:0] HALF = rrbb_pkg::PROD_W'(1) << (SH - 1);

	typedef logic [rrbb_pkg::MAG_W-1:0]  mag_t;
	typedef logic [rrbb_pkg::PROD_W-1:0] prod_t;

	function automatic mag_t mag_of(input logic signed [rrbb_pkg::XY_W-1:0] v);
		logic signed [rrbb_pkg::XY_W-1:0] a;
		a = v[rrbb_pkg::XY_W-1] ? -v : v;
		return a[rrbb_pkg::MAG_W-1:0];
	endfunction

	function automatic logic [rrbb_pkg::RND_W-1:0] round_of(input prod_t p);
		prod_t s;
		s = (p + HALF) >> SH;
		return s[rrbb_pkg::RND_W-1:0];
	endfunction

	logic  valid_s1;
	logic  valid_s2;
	logic  adv_s1;
	logic  adv_s2;
	prod_t px1_s1;
	prod_t px2_s1;
	prod_t py1_s1;
	prod_t py2_s1;
	rrbb_pkg::offs_t offs_s2;

	mag_t mx1;
	mag_t my1;
	mag_t mx2;
	mag_t my2;
	mag_t cos1;
	mag_t sin1;
	mag_t cos2;
	mag_t sin2;

	assign adv_s2   = !valid_s2 || dn_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_ready = adv_s1;
	assign dn_valid = valid_s2;
	assign dn_data  = offs_s2;

	always_comb begin
		mx1  = mag_of(up_data.c1.x);
		my1  = mag_of(up_data.c1.y);
		mx2  = mag_of(up_data.c2.x);
		my2  = mag_of(up_data.c2.y);
		cos1 = up_data.c1.quad[0] ? my1 : mx1;
		sin1 = up_data.c1.quad[0] ? mx1 : my1;
		cos2 = up_data.c2.quad[0] ? my2 : mx2;
		sin2 = up_data.c2.quad[0] ? mx2 : my2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= up_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			px1_s1 <= prod_t'(cos1) * prod_t'(up_data.len);
			px2_s1 <= prod_t'(cos2) * prod_t'(up_data.len);
			py1_s1 <= prod_t'(sin1) * prod_t'(up_data.len);
			py2_s1 <= prod_t'(sin2) * prod_t'(up_data.len);
		end
		if (adv_s2 && valid_s1) begin
			offs_s2.x1 <= round_of(px1_s1);
			offs_s2.x2 <= round_of(px2_s1);
			offs_s2.y1 <= round_of(py1_s1);
			offs_s2.y2 <= round_of(py2_s1);
		end
	end

endmodule

/* rtl/core/rrbb_span.sv */
module rrbb_span (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  rrbb_pkg::offs_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output rrbb_pkg::box_t  dn_data
);

	typedef logic [rrbb_pkg::RND_W:0] span_t;

	function automatic logic [15:0] sat_span(input logic [rrbb_pkg::RND_W-1:0] a,
		input logic [rrbb_pkg::RND_W-1:0] b);
		span_t s;
		s = {(a > b) ? a : b, 1'b0};
		return (s > span_t'(16'hFFFF)) ? 16'hFFFF : s[15:0];
	endfunction

	logic           valid_q;
	rrbb_pkg::box_t box_q;
	logic           adv;

	assign adv      = !valid_q || dn_ready;
	assign up_ready = adv;
	assign dn_valid = valid_q;
	assign dn_data  = box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			box_q.box_width  <= sat_span(up_data.x1, up_data.x2);
			box_q.box_height <= sat_span(up_data.y1, up_data.y2);
		end
	end

endmodule

/* rtl/core/rotated_rect_bounding_box.sv */
// Channel  Handshake                Payload
// item     item_valid / item_ready  rrbb_pkg::item_t (length, two corner angles, rotation)
// box      box_valid / box_ready    rrbb_pkg::box_t (box_width, box_height)
//
// One request per clock while the output is not stalled; stages: 23 CORDIC cells, multiply, round, span.
// Each stage has its own valid bit, so bubbles close up while the output stalls.
// Ready runs combinationally from box_ready back through all 26 stage registers.
// Reset clears only the valid bits.
module rotated_rect_bounding_box #(
	parameter int ANGLE_BITS       = rrbb_pkg::ANGLE_BITS_DEF,
	parameter int LENGTH_FRAC_BITS = rrbb_pkg::LENGTH_FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  rrbb_pkg::item_t item,
	output logic            box_valid,
	input  logic            box_ready,
	output rrbb_pkg::box_t  box
);

	localparam int CB = rrbb_pkg::CORDIC_BITS;
	localparam int NI = rrbb_pkg::CORDIC_ITERS;
	localparam logic [CB-1:0] AMASK = CB'((25'd1 << ANGLE_BITS) - 25'd1);

	typedef logic [CB-1:0] ang_t;

	function automatic rrbb_pkg::vec_t start_vec(input logic [15:0] a, input logic [15:0] r);
		rrbb_pkg::vec_t v;
		ang_t           s;
		s = ((ang_t'(a) + ang_t'(r)) & AMASK) << (CB - ANGLE_BITS);
		v.x    = rrbb_pkg::CORDIC_GAIN_Q30;
		v.y    = '0;
		v.z    = rrbb_pkg::Z_W'(s[CB-3:0]);
		v.quad = s[CB-1:CB-2];
		return v;
	endfunction

	rrbb_pkg::cell_data_t chain_d [NI+1];
	logic                 chain_v [NI+1];
	logic                 chain_r [NI+1];
	logic                 rnd_v;
	logic                 rnd_r;
	rrbb_pkg::offs_t      rnd_d;

	always_comb begin
		chain_d[0].c1  = start_vec(item.first_corner_angle, item.rotation);
		chain_d[0].c2  = start_vec(item.second_corner_angle, item.rotation);
		chain_d[0].len = item.half_diagonal;
	end

	assign chain_v[0] = item_valid;
	assign item_ready = chain_r[0];

	for (genvar g = 0; g < NI; g++) begin : g_cell
		rrbb_cordic_cell #(
			.STEP(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_v[g]),
			.up_ready (chain_r[g]),
			.up_data  (chain_d[g]),
			.dn_valid (chain_v[g+1]),
			.dn_ready (chain_r[g+1]),
			.dn_data  (chain_d[g+1])
		);
	end

	rrbb_scale #(
		.LENGTH_FRAC_BITS(LENGTH_FRAC_BITS)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_v[NI]),
		.up_ready (chain_r[NI]),
		.up_data  (chain_d[NI]),
		.dn_valid (rnd_v),
		.dn_ready (rnd_r),
		.dn_data  (rnd_d)
	);

	rrbb_span u_span (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (rnd_v),
		.up_ready (rnd_r),
		.up_data  (rnd_d),
		.dn_valid (box_valid),
		.dn_ready (box_ready),
		.dn_data  (box)
	);

endmodule

/* rtl/core/rrbb_checker.sv */
`include "assert_macros.svh"

module rrbb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_ready,
	input rrbb_pkg::item_t item,
	input logic            box_valid,
	input logic            box_ready,
	input rrbb_pkg::box_t  box
);

	`ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && !item_ready, item_valid && $stable(item))
	`ASSERT_NEXT(a_box_hold, clk, arst_n, box_valid && !box_ready, box_valid && $stable(box))
	`ASSERT_IMPLIES(a_width_even, clk, arst_n, box_valid, !box.box_width[0] || (&box.box_width))
	`ASSERT_IMPLIES(a_height_even, clk, arst_n, box_valid, !box.box_height[0] || (&box.box_height))

endmodule

bind rotated_rect_bounding_box rrbb_checker u_rrbb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.item       (item),
	.box_valid  (box_valid),
	.box_ready  (box_ready),
	.box        (box)
);

/* tb/sv/box_span_checker.sv */
`timescale 1ns / 100ps

module box_span_checker
	import rrbb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  logic  item_ready,
	input  item_t item,
	input  logic  box_valid,
	input  logic  box_ready,
	input  box_t  box,
	output int    mismatch_count,
	output int    boxes_in_flight
);

	localparam longint INV_GAIN_Q30 = 64'sd652032874;
	localparam int     ROTATIONS    = 23;
	localparam int     OFFSET_SHIFT = 34;

	longint arctan_turns [0:ROTATIONS-1] = '{
		2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
		10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
	};

	box_t pending_boxes [$];
	box_t oldest_box;
	int   mismatches = 0;
	int   in_flight  = 0;

	assign mismatch_count  = mismatches;
	assign boxes_in_flight = in_flight;

	function automatic void corner_cos_sin(input logic [15:0] angle, output longint c,
			output longint s);
		logic [23:0] turns;
		longint      x;
		longint      y;
		longint      z;
		longint      dx;
		longint      dy;
		turns = {angle, 8'h00};
		x = INV_GAIN_Q30;
		y = 0;
		z = longint'(turns[21:0]);
		for (int i = 0; i < ROTATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_turns[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_turns[i];
			end
		end
		case (turns[23:22])
			2'd0: begin
				c = x;
				s = y;
			end
			2'd1: begin
				c = -y;
				s = x;
			end
			2'd2: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase
	endfunction

	// round half away from zero to whole pixels
	function automatic longint pixel_offset(input logic [15:0] len, input longint q30);
		longint mag;
		longint r;
		mag = (q30 < 0) ? -q30 : q30;
		r = (mag * longint'({48'd0, len}) + (64'sd1 <<< (OFFSET_SHIFT - 1))) >>> OFFSET_SHIFT;
		return (q30 < 0) ? -r : r;
	endfunction

	function automatic logic [15:0] saturated_span(input longint a, input longint b);
		longint corners [0:3];
		longint hi;
		longint lo;
		corners = '{a, b, -a, -b};
		hi = a;
		lo = a;
		for (int k = 1; k < 4; k++) begin
			if (corners[k] > hi) hi = corners[k];
			if (corners[k] < lo) lo = corners[k];
		end
		if (hi - lo > 65535) return 16'hFFFF;
		return 16'(hi - lo);
	endfunction

	function automatic box_t predict_box(input item_t req);
		logic [15:0] a1;
		logic [15:0] a2;
		longint      c1;
		longint      s1;
		longint      c2;
		longint      s2;
		box_t        b;
		a1 = req.first_corner_angle + req.rotation;
		a2 = req.second_corner_angle + req.rotation;
		corner_cos_sin(a1, c1, s1);
		corner_cos_sin(a2, c2, s2);
		b.box_width = saturated_span(pixel_offset(req.half_diagonal, c1),
			pixel_offset(req.half_diagonal, c2));
		b.box_height = saturated_span(pixel_offset(req.half_diagonal, s1),
			pixel_offset(req.half_diagonal, s2));
		return b;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (box_valid && box_ready) begin
				if (pending_boxes.size() == 0) begin
					mismatches++;
					$display("%0t: box with no request pending: expected none, actual %0d x %0d",
						$time, box.box_width, box.box_height);
				end else begin
					oldest_box = pending_boxes.pop_front();
					if (box.box_width !== oldest_box.box_width) begin
						mismatches++;
						$display("%0t: box_width mismatch: expected %0d, actual %0d",
							$time, oldest_box.box_width, box.box_width);
					end
					if (box.box_height !== oldest_box.box_height) begin
						mismatches++;
						$display("%0t: box_height mismatch: expected %0d, actual %0d",
							$time, oldest_box.box_height, box.box_height);
					end
				end
			end
			if (item_valid && item_ready) pending_boxes.push_back(predict_box(item));
			in_flight = pending_boxes.size();
		end
	end

endmodule

/* tb/sv/tb_rotated_rect_bounding_box.sv */
`timescale 1ns / 100ps

module tb_rotated_rect_bounding_box;
	import rrbb_pkg::*;

	localparam int RANDOM_REQUESTS = 500;
	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_AT     = 400;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int DRAIN_CYCLES    = 40;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_ready;
	item_t item       = '0;
	logic  box_valid;
	logic  box_ready  = 1'b0;
	box_t  box;
	int    mismatch_count;
	int    boxes_in_flight;

	int send_idle_pct = 19;
	int recv_idle_pct = 47;
	int requests_sent = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;
	int quiet_cycles  = 0;

	rotated_rect_bounding_box dut (.*);

	box_span_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [15:0] rand_upto(input int unsigned lo, input int unsigned hi);
		logic [31:0] v;
		v = $urandom_range(hi, lo);
		return v[15:0];
	endfunction

	function automatic item_t make_request(input logic [15:0] len, input logic [15:0] a1,
			input logic [15:0] a2, input logic [15:0] rot);
		item_t r;
		r.half_diagonal       = len;
		r.first_corner_angle  = a1;
		r.second_corner_angle = a2;
		r.rotation            = rot;
		return r;
	endfunction

	function automatic item_t random_request();
		item_t       r;
		logic [15:0] base;
		r = make_request(rand_upto(0, 65535), rand_upto(0, 65535), rand_upto(0, 65535),
			rand_upto(0, 65535));
		case ($urandom_range(9))
			6: r.half_diagonal = rand_upto(0, 255);
			7: begin
				// land corners near quadrant boundaries
				base = rand_upto(0, 3) << 14;
				r.first_corner_angle  = base + rand_upto(0, 4) - 16'd2;
				r.second_corner_angle = base + 16'h4000 + rand_upto(0, 4) - 16'd2;
				r.rotation            = rand_upto(0, 3) << 14;
			end
			8: r.second_corner_angle = r.first_corner_angle + 16'h8000 - rand_upto(0, 16'h7FFF);
			9: r.half_diagonal = rand_upto(65280, 65535);
			default: ;
		endcase
		return r;
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		do @(posedge clk); while (!item_ready);
		requests_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			box_ready <= 1'b0;
		end else if (hold_left > 0) begin
			box_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && requests_sent >= HOLD_OFF_AT) begin
			// hold off so the pipeline fills and stalls the sender
			hold_done = 1'b1;
			hold_left = HOLD_OFF_CYCLES - 1;
			box_ready <= 1'b0;
		end else begin
			box_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (box_valid && box_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(make_request(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_request(make_request(16'h0000, 16'h1234, 16'h5678, 16'h0999));
		send_request(make_request(16'hFFFF, 16'h0000, 16'h4000, 16'h0000));
		send_request(make_request(16'hFFFF, 16'h2000, 16'h6000, 16'h0000));
		send_request(make_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(make_request(16'h0010, 16'h0000, 16'h8000, 16'h0000));
		send_request(make_request(16'h1000, 16'h1000, 16'h1000, 16'h0000));
		send_request(make_request(16'h1000, 16'hC000, 16'h4000, 16'h0000));
		send_request(make_request(16'h0008, 16'h0000, 16'h4000, 16'h0000));
		send_request(make_request(16'h0018, 16'h2000, 16'hE000, 16'h0000));
		send_request(make_request(16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000));
		send_request(make_request(16'h1234, 16'hF000, 16'h1000, 16'hF000));
		send_request(make_request(16'h8000, 16'h4000, 16'hC000, 16'h4000));
		send_request(make_request(16'hFFFF, 16'h3FFF, 16'h7FFF, 16'h0000));
		send_request(make_request(16'hFFFF, 16'h4001, 16'h8001, 16'hBFFF));
		send_request(make_request(16'h7FFF, 16'h5555, 16'hAAAA, 16'h1111));
		send_request(make_request(16'h0001, 16'h0000, 16'h4000, 16'h0000));
		send_request(make_request(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
		send_request(make_request(16'h00FF, 16'h1F00, 16'h9F00, 16'h0000));
		send_request(make_request(16'hFFFF, 16'h8000, 16'h0000, 16'hC000));

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_REQUESTS / 3) send_request(random_request());
		end
		item_valid <= 1'b0;

		while (boxes_in_flight != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
